// ===== hw/rtl/spr_pkg.sv =====
// Package for the status packet receiver.
// Holds the parse phase type, result kind codes and the result record.
// Used by spr_parser and status_packet_receiver_top.
package spr_pkg;

	localparam logic [7:0] HDR_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_ID   = 3'd2,
		PH_LEN  = 3'd3,
		PH_ERR  = 3'd4,
		PH_DATA = 3'd5,
		PH_SUM  = 3'd6
	} phase_t;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_GOOD   = 2'd1;
	localparam logic [1:0] KIND_BADSUM = 2'd2;
	localparam logic [1:0] KIND_FRAME  = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic [7:0] servo_id;
		logic [7:0] servo_error_flags;
		logic [7:0] data_count;
	} result_t;

endpackage

// ===== hw/rtl/spr_parser.sv =====
// Packet parse state and the combinational step for one received byte.
// Depends on spr_pkg; the result is registered by the top level.
module spr_parser
	import spr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] id_q, id_d;
	logic [7:0] len_q, len_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] err_q, err_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] count;
	logic       rearm;

	assign count = len_q - 8'd2;

	always_comb begin
		phase_d  = phase_q;
		id_d     = id_q;
		len_d    = len_q;
		remain_d = remain_q;
		err_d    = err_q;
		sum_d    = sum_q;
		rearm    = 1'b0;
		res      = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == HDR_BYTE) phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				if (rx_byte != HDR_BYTE) begin
					res.valid = 1'b1;
					res.kind  = KIND_FRAME;
					rearm     = 1'b1;
				end else begin
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_d   = rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (rx_byte < 8'd2) begin
					res.valid = 1'b1;
					res.kind  = KIND_FRAME;
					rearm     = 1'b1;
				end else begin
					len_d    = rx_byte;
					remain_d = rx_byte - 8'd2;
					sum_d    = sum_q + rx_byte;
					phase_d  = PH_ERR;
				end
			end
			PH_ERR: begin
				err_d   = rx_byte;
				sum_d   = sum_q + rx_byte;
				phase_d = (remain_q != 8'd0) ? PH_DATA : PH_SUM;
			end
			PH_DATA: begin
				sum_d                 = sum_q + rx_byte;
				res.valid             = 1'b1;
				res.kind              = KIND_DATA;
				res.data_byte         = rx_byte;
				res.data_index        = count - remain_q;
				res.servo_id          = id_q;
				res.servo_error_flags = err_q;
				res.data_count        = count;
				remain_d              = remain_q - 8'd1;
				if (remain_q == 8'd1) phase_d = PH_SUM;
			end
			PH_SUM: begin
				res.valid             = 1'b1;
				res.kind              = (~sum_q == rx_byte) ? KIND_GOOD : KIND_BADSUM;
				res.servo_id          = id_q;
				res.servo_error_flags = err_q;
				res.data_count        = count;
				rearm                 = 1'b1;
			end
			default: begin
				// An unused phase code clears the state and hunts.
				rearm   = 1'b1;
				phase_d = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
			end
		endcase
		if (rearm) begin
			if (phase_q == PH_HDR2 || phase_q == PH_LEN || phase_q == PH_SUM) begin
				phase_d = PH_HUNT;
			end
			id_d     = '0;
			len_d    = '0;
			remain_d = '0;
			err_d    = '0;
			sum_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			id_q     <= '0;
			len_q    <= '0;
			remain_q <= '0;
			err_q    <= '0;
			sum_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			id_q     <= id_d;
			len_q    <= len_d;
			remain_q <= remain_d;
			err_q    <= err_d;
			sum_q    <= sum_d;
		end
	end

endmodule

// ===== hw/rtl/status_packet_receiver_top.sv =====
// A word accepted into the input register is parsed, and its result is captured in the
// result register. Throughput: one word per cycle while no result waits unread; the parse
// step sits between the input and result registers. The input register is held, and input
// ready drops, only while a result waits unread. Reset is asynchronous and active low; it
// empties both registers and returns the parser to hunting for a header with all packet
// state cleared. Depends on spr_pkg and spr_parser.
module status_packet_receiver_top
	import spr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// data_byte, data_index, servo_id, servo_error_flags, data_count
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // result_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	result_t    res;
	result_t    res_s2;
	logic       advance;

	assign advance       = valid_s1 && (!res_s2.valid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	spr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= res;
		end else if (m_axis_tready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign m_axis_tvalid = res_s2.valid;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {res_s2.data_count, res_s2.servo_error_flags, res_s2.servo_id,
		res_s2.data_index, res_s2.data_byte};

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_FRAME |-> m_axis_tdata == 40'd0)
		else $error("framing error result carries packet fields");

	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[15:0] == 16'd0)
		else $error("end result carries a data byte or index");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a waiting word");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_DATA |-> m_axis_tdata[15:8] < m_axis_tdata[39:32])
		else $error("data index beyond data count");

endmodule
